// ===== rtl/alkpc_pkg.sv =====
package alkpc_pkg;

  // sample and level widths
  localparam int unsigned LevelW = 12;
  localparam int unsigned CountW = 8;
  localparam int unsigned KeyW   = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CountW-1:0] CountMax = 8'd255;

  // register reset values
  localparam logic [LevelW-1:0] ReleaseLevelRst  = 12'd1900;
  localparam logic [LevelW-1:0] Key4BelowRst     = 12'd400;
  localparam logic [LevelW-1:0] Key3BelowRst     = 12'd800;
  localparam logic [LevelW-1:0] Key2BelowRst     = 12'd1300;
  localparam logic [CountW-1:0] SettleSamplesRst = 8'd4;
  localparam logic [CountW-1:0] ShortMaxRst      = 8'd15;
  localparam logic [CountW-1:0] LongMinRst       = 8'd30;

  // key numbers
  localparam logic [KeyW-1:0] KeyNone = 3'd0;
  localparam logic [KeyW-1:0] KeyOne  = 3'd1;
  localparam logic [KeyW-1:0] KeyTwo  = 3'd2;
  localparam logic [KeyW-1:0] KeyThree = 3'd3;
  localparam logic [KeyW-1:0] KeyFour = 3'd4;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELEASE_LEVEL  = 3'd0,
    CFG_KEY4_BELOW     = 3'd1,
    CFG_KEY3_BELOW     = 3'd2,
    CFG_KEY2_BELOW     = 3'd3,
    CFG_SETTLE_SAMPLES = 3'd4,
    CFG_SHORT_MAX      = 3'd5,
    CFG_LONG_MIN       = 3'd6
  } cfg_idx_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PENDING   = 3'd1,
    ST_SHORT     = 3'd2,
    ST_LONG      = 3'd3,
    ST_DISCARDED = 3'd4
  } status_e;

  typedef struct packed {
    logic [LevelW-1:0] release_level;
    logic [LevelW-1:0] key4_below;
    logic [LevelW-1:0] key3_below;
    logic [LevelW-1:0] key2_below;
    logic [CountW-1:0] settle_samples;
    logic [CountW-1:0] short_max;
    logic [CountW-1:0] long_min;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] press_count;
    logic [LevelW-1:0] peak_level;
  } press_t;

endpackage

// ===== rtl/alkpc_classify.sv =====
module alkpc_classify (
  input  alkpc_pkg::cfg_t                 cfg_i,
  input  alkpc_pkg::press_t               press_i,
  input  logic [alkpc_pkg::LevelW-1:0]    sample_i,
  output alkpc_pkg::press_t               press_o,
  output alkpc_pkg::status_e              status_o,
  output logic [alkpc_pkg::KeyW-1:0]      key_o
);

  logic                            released;
  logic [alkpc_pkg::KeyW-1:0]      picked;
  logic [alkpc_pkg::CountW-1:0]    count_inc;

  assign released = sample_i > cfg_i.release_level;

  // key from peak, tested in fixed order
  always_comb begin
    priority if (press_i.peak_level < cfg_i.key4_below) begin
      picked = alkpc_pkg::KeyFour;
    end else if (press_i.peak_level < cfg_i.key3_below) begin
      picked = alkpc_pkg::KeyThree;
    end else if (press_i.peak_level < cfg_i.key2_below) begin
      picked = alkpc_pkg::KeyTwo;
    end else begin
      picked = alkpc_pkg::KeyOne;
    end
  end

  // saturating held count
  assign count_inc = (press_i.press_count == alkpc_pkg::CountMax) ?
                     press_i.press_count : press_i.press_count + 1'b1;

  // next press state and result
  always_comb begin
    press_o  = press_i;
    status_o = alkpc_pkg::ST_IDLE;
    key_o    = alkpc_pkg::KeyNone;
    if (released) begin
      if (press_i.press_count != '0) begin
        priority if (press_i.press_count > cfg_i.long_min) begin
          status_o = alkpc_pkg::ST_LONG;
          key_o    = picked;
        end else if (press_i.press_count <= cfg_i.short_max) begin
          status_o = alkpc_pkg::ST_SHORT;
          key_o    = picked;
        end else begin
          status_o = alkpc_pkg::ST_DISCARDED;
        end
        press_o.press_count = '0;
        press_o.peak_level  = '0;
      end
    end else begin
      press_o.press_count = count_inc;
      if (count_inc >= cfg_i.settle_samples && sample_i > press_i.peak_level) begin
        press_o.peak_level = sample_i;
      end
      status_o = alkpc_pkg::ST_PENDING;
    end
  end

endmodule

// ===== rtl/adc_ladder_key_press_classifier.sv =====
// channel | dir | beat fields      | handshake
// --------+-----+------------------+-------------------------------
// in      | in  | sample_i         | in_valid_i / in_stall_o
// out     | out | status_o, key_o  | out_valid_o / out_stall_i
// cfg     | in  | cfg_idx_i, data  | cfg_we_i, no wait
//
// one beat per cycle sustained while out_stall_i stays low; input register, then
// result register, with the classify logic sitting between the two.
// reset clears the press state, the valid flags and loads register defaults.
// a stalled result holds in the result register while the input register
// still takes a beat; in_stall_o rises only when both registers are full.
module adc_ladder_key_press_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [alkpc_pkg::LevelW-1:0]    sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [alkpc_pkg::KeyW-1:0]      key_o,
  input  logic                            cfg_we_i,
  input  logic [alkpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [alkpc_pkg::LevelW-1:0]    cfg_data_i
);

  alkpc_pkg::cfg_t                 cfg_q;
  alkpc_pkg::press_t               press_q, press_d;
  logic                            in_vld_q;
  logic [alkpc_pkg::LevelW-1:0]    sample_q;
  logic                            out_vld_q;
  alkpc_pkg::status_e              status_d, status_q;
  logic [alkpc_pkg::KeyW-1:0]      key_d, key_q;
  logic                            out_free;
  logic                            advance;
  logic                            in_take;

  // handshake
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_level  <= alkpc_pkg::ReleaseLevelRst;
      cfg_q.key4_below     <= alkpc_pkg::Key4BelowRst;
      cfg_q.key3_below     <= alkpc_pkg::Key3BelowRst;
      cfg_q.key2_below     <= alkpc_pkg::Key2BelowRst;
      cfg_q.settle_samples <= alkpc_pkg::SettleSamplesRst;
      cfg_q.short_max      <= alkpc_pkg::ShortMaxRst;
      cfg_q.long_min       <= alkpc_pkg::LongMinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alkpc_pkg::CFG_RELEASE_LEVEL:  cfg_q.release_level  <= cfg_data_i;
        alkpc_pkg::CFG_KEY4_BELOW:     cfg_q.key4_below     <= cfg_data_i;
        alkpc_pkg::CFG_KEY3_BELOW:     cfg_q.key3_below     <= cfg_data_i;
        alkpc_pkg::CFG_KEY2_BELOW:     cfg_q.key2_below     <= cfg_data_i;
        alkpc_pkg::CFG_SETTLE_SAMPLES: cfg_q.settle_samples <= cfg_data_i[7:0];
        alkpc_pkg::CFG_SHORT_MAX:      cfg_q.short_max      <= cfg_data_i[7:0];
        alkpc_pkg::CFG_LONG_MIN:       cfg_q.long_min       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
    end
  end

  alkpc_classify u_classify (
    .cfg_i    (cfg_q),
    .press_i  (press_q),
    .sample_i (sample_q),
    .press_o  (press_d),
    .status_o (status_d),
    .key_o    (key_d)
  );

  // press state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
    end else if (advance) begin
      press_q <= press_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      key_q    <= key_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign key_o       = key_q;

endmodule

// ===== rtl/alkpc_checker.sv =====
module alkpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [2:0] key_o
);

  // a key is named only on short and long beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_o != alkpc_pkg::KeyNone |->
      status_o == alkpc_pkg::ST_SHORT || status_o == alkpc_pkg::ST_LONG)
    else $error("key on a beat that is not short or long");

  // short and long beats always carry a key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == alkpc_pkg::ST_SHORT || status_o == alkpc_pkg::ST_LONG)
      |-> key_o != alkpc_pkg::KeyNone)
    else $error("short or long beat without a key");

  // input backs up only behind a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output could move");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(key_o))
    else $error("stalled result changed");

endmodule

bind adc_ladder_key_press_classifier alkpc_checker u_alkpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .key_o       (key_o)
);

// ===== tb/tb_adc_ladder_key_press_classifier.sv =====
`timescale 1ns / 1ps

module tb_adc_ladder_key_press_classifier;

  typedef logic [alkpc_pkg::LevelW-1:0] level_t;
  typedef logic [alkpc_pkg::CountW-1:0] count_t;
  typedef logic [alkpc_pkg::KeyW-1:0]   key_t;

  typedef struct packed {
    alkpc_pkg::status_e status;
    key_t               key;
  } key_report_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  level_t                        sample_i    = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [2:0]                    status_o;
  key_t                          key_o;
  logic                          cfg_we_i    = 1'b0;
  logic [alkpc_pkg::CfgIdxW-1:0] cfg_idx_i   = '0;
  level_t                        cfg_data_i  = '0;

  adc_ladder_key_press_classifier i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .key_o       (key_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // samples waiting to be sent and reports waiting to come back
  level_t            pending_samples[$];
  key_report_t       awaited_reports[$];
  int unsigned       items_queued = 0;
  int                phase_no     = 0;
  int                mismatch_cnt = 0;

  // press tracker shadow: register copy, held count, peak
  alkpc_pkg::cfg_t   regs;
  count_t            held_count;
  level_t            peak_seen;

  // peak to key, tested in fixed order key four, three, two
  function automatic key_t key_from_peak(level_t pk);
    if (pk < regs.key4_below) return alkpc_pkg::KeyFour;
    if (pk < regs.key3_below) return alkpc_pkg::KeyThree;
    if (pk < regs.key2_below) return alkpc_pkg::KeyTwo;
    return alkpc_pkg::KeyOne;
  endfunction

  // one sample in, one report out; updates the shadow press state
  function automatic key_report_t classify_sample(level_t smp);
    key_report_t r;
    r.status = alkpc_pkg::ST_PENDING;
    r.key    = alkpc_pkg::KeyNone;
    if (smp > regs.release_level) begin
      if (held_count == '0) begin
        r.status = alkpc_pkg::ST_IDLE;
      end else begin
        // long test first, so long wins when the limits overlap
        if (held_count > regs.long_min) begin
          r.status = alkpc_pkg::ST_LONG;
          r.key    = key_from_peak(peak_seen);
        end else if (held_count <= regs.short_max) begin
          r.status = alkpc_pkg::ST_SHORT;
          r.key    = key_from_peak(peak_seen);
        end else begin
          r.status = alkpc_pkg::ST_DISCARDED;
        end
        held_count = '0;
        peak_seen  = '0;
      end
    end else begin
      // count saturates, peak tracked once settled
      if (held_count != alkpc_pkg::CountMax) held_count = held_count + 1'b1;
      if (held_count >= regs.settle_samples && smp > peak_seen) peak_seen = smp;
    end
    return r;
  endfunction

  // sender: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) awaited_reports.push_back(classify_sample(sample_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || pending_samples.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          sample_i   <= pending_samples.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if ($urandom_range(0, 19) == 0) gap_left = 25;
          end
        end
      end
    end
  end

  // receiver: stall pattern in modes, long hold-off on some phases
  key_report_t want;
  int          holdoff_left = 0;
  int          held_phase   = -1;
  int          pattern_left = 0;
  int          stall_mode   = 0;
  logic        rand_stall   = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result beat: status %0d key %0d", status_o, key_o);
          mismatch_cnt++;
        end else begin
          want = awaited_reports.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            mismatch_cnt++;
          end
          if (key_o !== want.key) begin
            $error("key: expected %0d, actual %0d", want.key, key_o);
            mismatch_cnt++;
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
      end else if (phase_no != held_phase && phase_no % 3 == 1) begin
        holdoff_left = 60;
        held_phase   = phase_no;
      end
      if (pattern_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        pattern_left = $urandom_range(10, 80);
      end else begin
        pattern_left--;
      end
      case (stall_mode)
        0: rand_stall = 1'b0;
        1: rand_stall = ($urandom_range(0, 3) == 0);
        2: rand_stall = ($urandom_range(0, 3) != 0);
        default: rand_stall = ~rand_stall;
      endcase
      out_stall_i <= (holdoff_left > 0) || rand_stall;
    end
  end

  task automatic queue_sample(level_t v);
    pending_samples.push_back(v);
    items_queued++;
  endtask

  // a sample above the release level, if one exists
  task automatic queue_release();
    if (regs.release_level != 12'hFFF)
      queue_sample(level_t'($urandom_range(int'(regs.release_level) + 1, 4095)));
  endtask

  // held level, often straddling a key threshold
  function automatic level_t pick_held_level();
    int v;
    int rel;
    rel = int'(regs.release_level);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = rel;
      2: v = int'(regs.key4_below) - 1 + $urandom_range(0, 1);
      3: v = int'(regs.key3_below) - 1 + $urandom_range(0, 1);
      4: v = int'(regs.key2_below) - 1 + $urandom_range(0, 1);
      default: v = $urandom_range(0, rel);
    endcase
    if (v < 0) v = 0;
    if (v > rel) v = rel;
    return v[alkpc_pkg::LevelW-1:0];
  endfunction

  // press lengths around settle, short and long limits
  function automatic int pick_press_len();
    int n;
    case ($urandom_range(0, 9))
      0: n = 1;
      1: n = int'(regs.settle_samples);
      2: n = int'(regs.settle_samples) + 1;
      3: n = int'(regs.short_max);
      4: n = int'(regs.short_max) + 1;
      5: n = int'(regs.long_min);
      6: n = int'(regs.long_min) + 1;
      7: n = int'(regs.long_min) + 2;
      default: n = $urandom_range(1, 12);
    endcase
    if (n < 1) n = 1;
    if (n > 300) n = 300;
    return n;
  endfunction

  // mostly whole presses, some noise, idle releases and broken presses
  task automatic gen_traffic(int budget, bit end_open);
    int unsigned stop_at;
    int          len;
    int          pick;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_sample(level_t'($urandom_range(0, 4095)));
      end else if (pick < 16) begin
        queue_release();
      end else begin
        len = pick_press_len();
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 3) queue_sample(level_t'($urandom_range(0, 4095)));
          else queue_sample(pick_held_level());
        end
        queue_release();
      end
    end
    // leave a press open across the pause and register change
    if (end_open) repeat ($urandom_range(1, 6)) queue_sample(pick_held_level());
  endtask

  // wait until every beat has been sent and every report has come back
  task automatic drain_reports();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || awaited_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int budget, bit end_open);
    gen_traffic(budget, end_open);
    phase_no++;
    drain_reports();
  endtask

  task automatic write_reg(alkpc_pkg::cfg_idx_e idx, level_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      alkpc_pkg::CFG_RELEASE_LEVEL:  regs.release_level  = val;
      alkpc_pkg::CFG_KEY4_BELOW:     regs.key4_below     = val;
      alkpc_pkg::CFG_KEY3_BELOW:     regs.key3_below     = val;
      alkpc_pkg::CFG_KEY2_BELOW:     regs.key2_below     = val;
      alkpc_pkg::CFG_SETTLE_SAMPLES: regs.settle_samples = val[alkpc_pkg::CountW-1:0];
      alkpc_pkg::CFG_SHORT_MAX:      regs.short_max      = val[alkpc_pkg::CountW-1:0];
      alkpc_pkg::CFG_LONG_MIN:       regs.long_min       = val[alkpc_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int rel, int k4, int k3, int k2, int st, int sm, int lm);
    write_reg(alkpc_pkg::CFG_RELEASE_LEVEL, level_t'(rel));
    write_reg(alkpc_pkg::CFG_KEY4_BELOW, level_t'(k4));
    write_reg(alkpc_pkg::CFG_KEY3_BELOW, level_t'(k3));
    write_reg(alkpc_pkg::CFG_KEY2_BELOW, level_t'(k2));
    write_reg(alkpc_pkg::CFG_SETTLE_SAMPLES, level_t'(st));
    write_reg(alkpc_pkg::CFG_SHORT_MAX, level_t'(sm));
    write_reg(alkpc_pkg::CFG_LONG_MIN, level_t'(lm));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random settings, thresholds usually ordered and under the release level
  task automatic random_regs();
    int rel;
    int lim;
    int a;
    int b;
    int c;
    int tmp;
    int st;
    int sm;
    int lm;
    case ($urandom_range(0, 9))
      0: rel = 0;
      1: rel = 4095;
      default: rel = $urandom_range(200, 3900);
    endcase
    lim = (rel < 4095) ? rel + 1 : 4095;
    a = $urandom_range(0, lim);
    b = $urandom_range(0, lim);
    c = $urandom_range(0, lim);
    if ($urandom_range(0, 3) != 0) begin
      if (a > b) begin tmp = a; a = b; b = tmp; end
      if (b > c) begin tmp = b; b = c; c = tmp; end
      if (a > b) begin tmp = a; a = b; b = tmp; end
    end
    case ($urandom_range(0, 9))
      0: st = 0;
      1: st = 255;
      default: st = $urandom_range(0, 8);
    endcase
    case ($urandom_range(0, 9))
      0: sm = 0;
      1: sm = 255;
      default: sm = $urandom_range(0, 16);
    endcase
    case ($urandom_range(0, 9))
      0: lm = 0;
      1: lm = 254;
      default: lm = $urandom_range(0, 30);
    endcase
    set_regs(rel, a, b, c, st, sm, lm);
  endtask

  initial begin
    regs.release_level  = alkpc_pkg::ReleaseLevelRst;
    regs.key4_below     = alkpc_pkg::Key4BelowRst;
    regs.key3_below     = alkpc_pkg::Key3BelowRst;
    regs.key2_below     = alkpc_pkg::Key2BelowRst;
    regs.settle_samples = alkpc_pkg::SettleSamplesRst;
    regs.short_max      = alkpc_pkg::ShortMaxRst;
    regs.long_min       = alkpc_pkg::LongMinRst;
    held_count          = '0;
    peak_seen           = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings: idle releases, then four short presses, one per key;
    // the first held sample of a press is below the settle count and not tracked
    queue_sample(12'd4095);
    queue_sample(12'd1901);
    queue_sample(12'd1900);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd399);
    queue_sample(12'd1901);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd799);
    queue_sample(12'd4095);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd800);
    queue_sample(12'd2000);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd1300);
    queue_sample(12'd3000);
    phase_no++;
    drain_reports();

    // nothing releases: every sample held, count saturates, zero settle
    set_regs(4095, 0, 0, 0, 0, 0, 0);
    repeat (300) queue_sample(level_t'($urandom_range(0, 4095)));
    phase_no++;
    drain_reports();

    // inverted thresholds, widest limits; saturated press ends as long
    set_regs(2048, 4095, 0, 0, 255, 255, 254);
    run_phase(100, 1'b0);

    // only a zero sample is held; one-beat press discarded, longer is long
    set_regs(0, 1, 2, 3, 1, 0, 1);
    run_phase(80, 1'b1);

    // overlapping limits, long wins
    set_regs(1900, 400, 800, 1300, 2, 20, 5);
    run_phase(100, 1'b0);

    // gap between short and long, discarded presses
    set_regs(1900, 400, 800, 1300, 1, 3, 8);
    run_phase(100, 1'b1);

    while (items_queued < 1650) begin
      random_regs();
      run_phase(120, $urandom_range(0, 3) == 0);
    end

    drain_reports();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
